[hdl/assert_macros.svh]
// Assertion macros shared by the queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CGQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CGQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cgq_pkg.sv]
// Types, constants and codes for the class grouped queue.
package cgq_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int CLASS_DEPTH = 1024;

    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int PTR_W   = $clog2(CLASS_DEPTH);
    localparam int CNT_W   = $clog2(CLASS_DEPTH + 1);
    localparam int OCNT_W  = $clog2(NUM_CLASSES + 1);
    localparam int ADDR_W  = CLS_W + PTR_W;
    localparam int RAM_DEPTH = 2 ** ADDR_W;
    localparam int SUM_W   = PTR_W + 1;
    localparam int OSUM_W  = CLS_W + 1;

    localparam int OPCODE_W = 1;
    localparam int CLASS_W  = 3;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_ENQ = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ENQ   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DEQ   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_HOLD
    } cgq_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
    } cgq_cmd_t;

    typedef struct packed {
        logic rd_pending;
    } cgq_sts_t;

endpackage

[hdl/cgq_ram.sv]
// Generic single-port RAM with registered read.
module cgq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

[hdl/cgq_ctrl.sv]
// Controller state machine: sequences accept, execute, store read and result hand-off.
`include "assert_macros.svh"

module cgq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  cgq_pkg::cgq_sts_t  sts,
    output cgq_pkg::cgq_cmd_t  cmd
);

    cgq_pkg::cgq_state_t state_reg;
    cgq_pkg::cgq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cgq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cgq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cgq_pkg::S_EXEC;
                end
            end
            cgq_pkg::S_EXEC:
            begin
                state_next = sts.rd_pending ? cgq_pkg::S_READ : cgq_pkg::S_HOLD;
            end
            cgq_pkg::S_READ:
            begin
                state_next = cgq_pkg::S_HOLD;
            end
            cgq_pkg::S_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = cgq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cgq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.load    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            cgq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            cgq_pkg::S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            cgq_pkg::S_READ:
            begin
                cmd.capture = 1'b1;
            end
            cgq_pkg::S_HOLD:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    `CGQ_ASSERT_SAME(a_no_overlap, in_ready, !out_valid, "ready and result valid together")
    `CGQ_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, cmd.exec, "accepted word not executed")
    `CGQ_ASSERT_NEXT(a_read_capture, cmd.exec && sts.rd_pending, cmd.capture,
        "store read not captured")

endmodule

[hdl/cgq_dpath.sv]
// Datapath: class FIFO pointers, class order ring, item store and result register.
`include "assert_macros.svh"

module cgq_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cgq_pkg::cgq_cmd_t                 cmd,
    output cgq_pkg::cgq_sts_t                 sts,
    input  logic [cgq_pkg::OPCODE_W-1:0]      opcode,
    input  logic [cgq_pkg::CLASS_W-1:0]       class_id,
    input  logic [cgq_pkg::ID_W-1:0]          item_id,
    output logic [cgq_pkg::STATUS_W-1:0]      status,
    output logic [cgq_pkg::CLASS_W-1:0]       out_class,
    output logic [cgq_pkg::ID_W-1:0]          out_id
);

    logic [cgq_pkg::OPCODE_W-1:0] op_reg;
    logic [cgq_pkg::CLASS_W-1:0]  cls_reg;
    logic [cgq_pkg::ID_W-1:0]     id_reg;

    logic [cgq_pkg::PTR_W-1:0]  head_reg [cgq_pkg::NUM_CLASSES];
    logic [cgq_pkg::PTR_W-1:0]  head_next [cgq_pkg::NUM_CLASSES];
    logic [cgq_pkg::CNT_W-1:0]  cnt_reg [cgq_pkg::NUM_CLASSES];
    logic [cgq_pkg::CNT_W-1:0]  cnt_next [cgq_pkg::NUM_CLASSES];
    logic [cgq_pkg::CLS_W-1:0]  ring_reg [cgq_pkg::NUM_CLASSES];
    logic [cgq_pkg::CLS_W-1:0]  ring_next [cgq_pkg::NUM_CLASSES];
    logic [cgq_pkg::CLS_W-1:0]  ohead_reg;
    logic [cgq_pkg::CLS_W-1:0]  ohead_next;
    logic [cgq_pkg::OCNT_W-1:0] ocnt_reg;
    logic [cgq_pkg::OCNT_W-1:0] ocnt_next;

    logic [cgq_pkg::STATUS_W-1:0] status_reg;
    logic [cgq_pkg::STATUS_W-1:0] status_next;
    logic [cgq_pkg::CLASS_W-1:0]  oclass_reg;
    logic [cgq_pkg::CLASS_W-1:0]  oclass_next;
    logic [cgq_pkg::ID_W-1:0]     oid_reg;
    logic [cgq_pkg::ID_W-1:0]     oid_next;

    logic                         enq_cls_ok;
    logic [cgq_pkg::CLS_W-1:0]    enq_c;
    logic [cgq_pkg::CLS_W-1:0]    sel_c;
    logic [cgq_pkg::PTR_W-1:0]    sel_head;
    logic [cgq_pkg::CNT_W-1:0]    sel_cnt;
    logic [cgq_pkg::SUM_W-1:0]    slot_sum;
    logic [cgq_pkg::PTR_W-1:0]    slot;
    logic [cgq_pkg::PTR_W-1:0]    head_inc;
    logic [cgq_pkg::OSUM_W-1:0]   opos_sum;
    logic [cgq_pkg::CLS_W-1:0]    opos;
    logic [cgq_pkg::CLS_W-1:0]    ohead_inc;

    logic                         ram_en;
    logic                         ram_we;
    logic [cgq_pkg::ADDR_W-1:0]   ram_addr;
    logic [cgq_pkg::ID_W-1:0]     ram_rdata;
    logic                         rd_pending;

    assign enq_cls_ok = (cls_reg != '0) && (32'(cls_reg) <= cgq_pkg::NUM_CLASSES);
    assign enq_c      = cgq_pkg::CLS_W'(32'(cls_reg) - 32'd1);
    assign sel_c      = (op_reg == cgq_pkg::OP_DEQ) ? ring_reg[ohead_reg] : enq_c;
    assign sel_head   = head_reg[sel_c];
    assign sel_cnt    = cnt_reg[sel_c];

    assign slot_sum = cgq_pkg::SUM_W'(sel_head) + cgq_pkg::SUM_W'(sel_cnt);
    assign slot     = (slot_sum >= cgq_pkg::SUM_W'(cgq_pkg::CLASS_DEPTH))
                    ? cgq_pkg::PTR_W'(slot_sum - cgq_pkg::SUM_W'(cgq_pkg::CLASS_DEPTH))
                    : cgq_pkg::PTR_W'(slot_sum);
    assign head_inc = (sel_head == cgq_pkg::PTR_W'(cgq_pkg::CLASS_DEPTH - 1))
                    ? '0 : sel_head + 1'b1;

    assign opos_sum  = cgq_pkg::OSUM_W'(ohead_reg) + cgq_pkg::OSUM_W'(ocnt_reg);
    assign opos      = (opos_sum >= cgq_pkg::OSUM_W'(cgq_pkg::NUM_CLASSES))
                     ? cgq_pkg::CLS_W'(opos_sum - cgq_pkg::OSUM_W'(cgq_pkg::NUM_CLASSES))
                     : cgq_pkg::CLS_W'(opos_sum);
    assign ohead_inc = (ohead_reg == cgq_pkg::CLS_W'(cgq_pkg::NUM_CLASSES - 1))
                     ? '0 : ohead_reg + 1'b1;

    always_comb
    begin
        head_next   = head_reg;
        cnt_next    = cnt_reg;
        ring_next   = ring_reg;
        ohead_next  = ohead_reg;
        ocnt_next   = ocnt_reg;
        status_next = status_reg;
        oclass_next = oclass_reg;
        oid_next    = oid_reg;
        ram_en      = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = {sel_c, slot};
        rd_pending  = 1'b0;

        if (cmd.exec)
        begin
            oclass_next = '0;
            oid_next    = '0;
            if (op_reg == cgq_pkg::OP_ENQ)
            begin
                if (!enq_cls_ok || sel_cnt == cgq_pkg::CNT_W'(cgq_pkg::CLASS_DEPTH))
                begin
                    status_next = cgq_pkg::ST_FULL;
                end
                else
                begin
                    ram_en   = 1'b1;
                    ram_we   = 1'b1;
                    ram_addr = {sel_c, slot};
                    if (sel_cnt == '0 && 32'(ocnt_reg) < cgq_pkg::NUM_CLASSES)
                    begin
                        ring_next[opos] = sel_c;
                        ocnt_next       = ocnt_reg + 1'b1;
                    end
                    cnt_next[sel_c] = sel_cnt + 1'b1;
                    status_next     = cgq_pkg::ST_ENQ;
                end
            end
            else
            begin
                if (ocnt_reg == '0 || sel_cnt == '0)
                begin
                    status_next = cgq_pkg::ST_EMPTY;
                end
                else
                begin
                    ram_en           = 1'b1;
                    ram_addr         = {sel_c, sel_head};
                    rd_pending       = 1'b1;
                    head_next[sel_c] = head_inc;
                    cnt_next[sel_c]  = sel_cnt - 1'b1;
                    if (sel_cnt == cgq_pkg::CNT_W'(1))
                    begin
                        ohead_next = ohead_inc;
                        ocnt_next  = ocnt_reg - 1'b1;
                    end
                    status_next = cgq_pkg::ST_DEQ;
                    oclass_next = cgq_pkg::CLASS_W'(32'(sel_c) + 32'd1);
                end
            end
        end
        else if (cmd.capture)
        begin
            oid_next = ram_rdata;
        end
    end

    assign sts.rd_pending = rd_pending;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cgq_pkg::NUM_CLASSES; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            ohead_reg <= '0;
            ocnt_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            ohead_reg <= ohead_next;
            ocnt_reg  <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            cls_reg <= class_id;
            id_reg  <= item_id;
        end
        ring_reg   <= ring_next;
        status_reg <= status_next;
        oclass_reg <= oclass_next;
        oid_reg    <= oid_next;
    end

    cgq_ram #(
        .WIDTH (cgq_pkg::ID_W),
        .DEPTH (cgq_pkg::RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (id_reg),
        .rdata (ram_rdata)
    );

    assign status    = status_reg;
    assign out_class = oclass_reg;
    assign out_id    = oid_reg;

    `CGQ_ASSERT_SAME(a_ocnt_range, 1'b1, 32'(ocnt_reg) <= cgq_pkg::NUM_CLASSES,
        "class order count out of range")
    `CGQ_ASSERT_SAME(a_read_nonempty, rd_pending, ocnt_reg != '0 && sel_cnt != '0,
        "store read from empty class")
    `CGQ_ASSERT_NEXT(a_deq_status, rd_pending, status_reg == cgq_pkg::ST_DEQ,
        "dequeue status not recorded")

endmodule

[hdl/class_grouped_queue.sv]
// Top level of the class grouped queue: controller plus datapath.
// Each command word passes through the accept, execute and hand-off states, with a registered
// store read between execute and hand-off on a dequeue; a new word is accepted only once
// the result has been taken with out_ready high.
// Reset (rst_n low, asynchronous) empties every class and the class order;
// the item store holds no reset value and needs no clearing pass.
module class_grouped_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cgq_pkg::OPCODE_W-1:0]  opcode,
    input  logic [cgq_pkg::CLASS_W-1:0]   class_id,
    input  logic [cgq_pkg::ID_W-1:0]      item_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cgq_pkg::STATUS_W-1:0]  status,
    output logic [cgq_pkg::CLASS_W-1:0]   out_class,
    output logic [cgq_pkg::ID_W-1:0]      out_id
);

    cgq_pkg::cgq_cmd_t cmd;
    cgq_pkg::cgq_sts_t sts;

    cgq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    cgq_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .opcode    (opcode),
        .class_id  (class_id),
        .item_id   (item_id),
        .status    (status),
        .out_class (out_class),
        .out_id    (out_id)
    );

endmodule

[tb/team_order_checker.sv]
// Checker for the class grouped queue: predicts each answer and compares it with the block.
module team_order_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [cgq_pkg::OPCODE_W-1:0]  opcode,
    input  logic [cgq_pkg::CLASS_W-1:0]   class_id,
    input  logic [cgq_pkg::ID_W-1:0]      item_id,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [cgq_pkg::STATUS_W-1:0]  status,
    input  logic [cgq_pkg::CLASS_W-1:0]   out_class,
    input  logic [cgq_pkg::ID_W-1:0]      out_id,
    output int                            faults,
    output int                            waiting,
    output int                            deq_seen,
    output int                            full_seen,
    output int                            empty_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [cgq_pkg::STATUS_W-1:0] status;
        logic [cgq_pkg::CLASS_W-1:0]  cls;
        logic [cgq_pkg::ID_W-1:0]     id;
    } answer_t;

    logic [cgq_pkg::ID_W-1:0] id_store [cgq_pkg::NUM_CLASSES][cgq_pkg::CLASS_DEPTH];
    int unsigned              cls_head [cgq_pkg::NUM_CLASSES];
    int unsigned              cls_fill [cgq_pkg::NUM_CLASSES];
    int unsigned              serve_ring [cgq_pkg::NUM_CLASSES];
    int unsigned              serve_head;
    int unsigned              serve_fill;
    answer_t                  due_answers [$];
    int                       fault_tally;

    function automatic answer_t serve_command(logic [cgq_pkg::OPCODE_W-1:0] op,
                                              logic [cgq_pkg::CLASS_W-1:0] cls,
                                              logic [cgq_pkg::ID_W-1:0] id);
        answer_t     ans;
        int unsigned c;
        int unsigned slot;
        ans.status = cgq_pkg::ST_ENQ;
        ans.cls    = '0;
        ans.id     = '0;
        if (op == cgq_pkg::OP_ENQ)
        begin
            if (cls < 1 || cls > cgq_pkg::NUM_CLASSES)
            begin
                ans.status = cgq_pkg::ST_FULL;
            end
            else
            begin
                c = 32'(cls) - 1;
                if (cls_fill[c] >= cgq_pkg::CLASS_DEPTH)
                begin
                    ans.status = cgq_pkg::ST_FULL;
                end
                else
                begin
                    slot = (cls_head[c] + cls_fill[c]) % cgq_pkg::CLASS_DEPTH;
                    id_store[c][slot] = id;
                    if (cls_fill[c] == 0)
                    begin
                        serve_ring[(serve_head + serve_fill) % cgq_pkg::NUM_CLASSES] = c;
                        serve_fill++;
                    end
                    cls_fill[c]++;
                end
            end
        end
        else if (serve_fill == 0)
        begin
            ans.status = cgq_pkg::ST_EMPTY;
        end
        else
        begin
            c = serve_ring[serve_head];
            ans.status = cgq_pkg::ST_DEQ;
            ans.cls    = cgq_pkg::CLASS_W'(c + 1);
            ans.id     = id_store[c][cls_head[c]];
            cls_head[c] = (cls_head[c] + 1) % cgq_pkg::CLASS_DEPTH;
            cls_fill[c]--;
            if (cls_fill[c] == 0)
            begin
                serve_head = (serve_head + 1) % cgq_pkg::NUM_CLASSES;
                serve_fill--;
            end
        end
        return ans;
    endfunction

    task automatic report_fault(string what, answer_t want, answer_t got);
        if (fault_tally < 10)
        begin
            $display("%0t: %s: expected status %0d class %0d id %h,",
                     $realtime, what, want.status, want.cls, want.id);
            $display("    got status %0d class %0d id %h", got.status, got.cls, got.id);
        end
        fault_tally++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            for (int c = 0; c < cgq_pkg::NUM_CLASSES; c++)
            begin
                cls_head[c] = 0;
                cls_fill[c] = 0;
            end
            serve_head  = 0;
            serve_fill  = 0;
            fault_tally = 0;
            due_answers.delete();
            faults     <= 0;
            waiting    <= 0;
            deq_seen   <= 0;
            full_seen  <= 0;
            empty_seen <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                due_answers.insert(due_answers.size(),
                                   serve_command(opcode, class_id, item_id));
            end
            if (out_valid && out_ready)
            begin
                got.status = status;
                got.cls    = out_class;
                got.id     = out_id;
                if (due_answers.size() == 0)
                begin
                    want = '0;
                    report_fault("unexpected word", want, got);
                end
                else
                begin
                    want = due_answers.pop_front();
                    if (want.status !== got.status || want.cls !== got.cls
                        || want.id !== got.id)
                    begin
                        report_fault("mismatch", want, got);
                    end
                end
                if (got.status == cgq_pkg::ST_DEQ)
                begin
                    deq_seen <= deq_seen + 1;
                end
                if (got.status == cgq_pkg::ST_FULL)
                begin
                    full_seen <= full_seen + 1;
                end
                if (got.status == cgq_pkg::ST_EMPTY)
                begin
                    empty_seen <= empty_seen + 1;
                end
            end
            faults  <= fault_tally;
            waiting <= due_answers.size();
        end
    end

endmodule

[tb/tb.sv]
// Top of the class grouped queue testbench: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD = 400;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [cgq_pkg::OPCODE_W-1:0] opcode;
    logic [cgq_pkg::CLASS_W-1:0]  class_id;
    logic [cgq_pkg::ID_W-1:0]     item_id;
    logic                         out_valid;
    logic                         out_ready;
    logic [cgq_pkg::STATUS_W-1:0] status;
    logic [cgq_pkg::CLASS_W-1:0]  out_class;
    logic [cgq_pkg::ID_W-1:0]     out_id;

    int faults;
    int waiting;
    int deq_seen;
    int full_seen;
    int empty_seen;
    int words_sent = 0;
    int sender_mode = 0;
    int hold_requests = 0;
    int holds_done = 0;

    class_grouped_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .class_id  (class_id),
        .item_id   (item_id),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_class (out_class),
        .out_id    (out_id)
    );

    team_order_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .class_id   (class_id),
        .item_id    (item_id),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .out_class  (out_class),
        .out_id     (out_id),
        .faults     (faults),
        .waiting    (waiting),
        .deq_seen   (deq_seen),
        .full_seen  (full_seen),
        .empty_seen (empty_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (sender_mode == 0 || roll < 60)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return int'($urandom_range(1, 3));
        end
        if (roll < 98)
        begin
            return int'($urandom_range(4, 12));
        end
        return int'($urandom_range(20, 60));
    endfunction

    task automatic send_word(logic [cgq_pkg::OPCODE_W-1:0] op,
                             logic [cgq_pkg::CLASS_W-1:0] cls,
                             logic [cgq_pkg::ID_W-1:0] id);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        opcode   = op;
        class_id = cls;
        item_id  = id;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (waiting != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_random(int enq_pct);
        logic [cgq_pkg::CLASS_W-1:0] cls;
        if ($urandom_range(0, 99) < enq_pct)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                cls = $urandom_range(0, 1) ? '0
                    : cgq_pkg::CLASS_W'($urandom_range(cgq_pkg::NUM_CLASSES + 1, 7));
            end
            else
            begin
                cls = cgq_pkg::CLASS_W'($urandom_range(1, cgq_pkg::NUM_CLASSES));
            end
            send_word(cgq_pkg::OP_ENQ, cls, cgq_pkg::ID_W'($urandom));
        end
        else
        begin
            send_word(cgq_pkg::OP_DEQ, cgq_pkg::CLASS_W'($urandom), cgq_pkg::ID_W'($urandom));
        end
    endtask

    task automatic fill_one_class();
        logic [cgq_pkg::CLASS_W-1:0] cls;
        cls = cgq_pkg::CLASS_W'($urandom_range(1, cgq_pkg::NUM_CLASSES));
        sender_mode = 0;
        hold_requests++;
        for (int i = 0; i < cgq_pkg::CLASS_DEPTH + 3; i++)
        begin
            send_word(cgq_pkg::OP_ENQ, cls, cgq_pkg::ID_W'($urandom));
        end
        send_word(cgq_pkg::OP_ENQ,
                  cgq_pkg::CLASS_W'((32'(cls) % cgq_pkg::NUM_CLASSES) + 1),
                  cgq_pkg::ID_W'($urandom));
        wait_drained();
        for (int i = 0; i < 50; i++)
        begin
            send_word(cgq_pkg::OP_DEQ, cgq_pkg::CLASS_W'($urandom), cgq_pkg::ID_W'($urandom));
        end
        wait_drained();
    endtask

    initial
    begin
        int stretch_left;
        int ready_pct;
        out_ready = 1'b0;
        stretch_left = 0;
        ready_pct = 100;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                holds_done++;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = int'($urandom_range(10, 120));
                    case ($urandom_range(0, 9)) inside
                        [0:2]: ready_pct = 100;
                        [3:5]: ready_pct = 80;
                        [6:7]: ready_pct = 50;
                        8:     ready_pct = 20;
                        default:
                        begin
                            ready_pct = 0;
                            stretch_left = int'($urandom_range(5, 40));
                        end
                    endcase
                end
                stretch_left--;
                out_ready = ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    initial
    begin
        int spin;
        int enq_pct;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        opcode   = cgq_pkg::OP_ENQ;
        class_id = '0;
        item_id  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(cgq_pkg::OP_DEQ, 3'd0, 16'h0000);
        send_word(cgq_pkg::OP_ENQ, 3'd0, 16'hFFFF);
        send_word(cgq_pkg::OP_ENQ, 3'd5, 16'h1234);
        send_word(cgq_pkg::OP_ENQ, 3'd7, 16'h0000);
        send_word(cgq_pkg::OP_ENQ, 3'd1, 16'h0000);
        send_word(cgq_pkg::OP_ENQ, 3'd2, 16'hFFFF);
        send_word(cgq_pkg::OP_ENQ, 3'd1, 16'h5A5A);
        send_word(cgq_pkg::OP_ENQ, 3'd3, 16'hA5A5);
        send_word(cgq_pkg::OP_ENQ, 3'd4, 16'h0001);
        send_word(cgq_pkg::OP_ENQ, 3'd2, 16'h8000);
        for (int i = 0; i < 7; i++)
        begin
            send_word(cgq_pkg::OP_DEQ, 3'd7, 16'hFFFF);
        end
        send_word(cgq_pkg::OP_ENQ, 3'd4, 16'h7FFF);
        send_word(cgq_pkg::OP_DEQ, 3'd0, 16'h0000);
        send_word(cgq_pkg::OP_DEQ, 3'd0, 16'h0000);
        wait_drained();

        for (int blk = 0; blk < 7; blk++)
        begin
            case ($urandom_range(0, 3))
                0: enq_pct = 35;
                1: enq_pct = 50;
                2: enq_pct = 65;
                default: enq_pct = 80;
            endcase
            sender_mode = ($urandom_range(0, 2) != 0) ? 1 : 0;
            if (blk == 1 || blk == 5)
            begin
                hold_requests++;
            end
            if (blk == 3)
            begin
                wait_drained();
                fill_one_class();
                sender_mode = 1;
            end
            for (int i = 0; i < 100; i++)
            begin
                send_random(enq_pct);
            end
        end

        in_valid = 1'b0;
        spin = 0;
        while (waiting != 0 && spin < 50000)
        begin
            spin++;
            @(negedge clk);
        end
        repeat (10) @(negedge clk);

        $display("Sent %0d commands; %0d items dequeued, %0d refused enqueues, %0d empty dequeues.",
                 words_sent, deq_seen, full_seen, empty_seen);
        $display("Covered a full class store, out-of-range classes and a long output stall.");
        if (faults == 0 && waiting == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
